/* hdl/tsd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

  // Table sizes
  localparam int NODE_DEPTH    = 1024;
  localparam int EDGE_DEPTH    = 1024;
  localparam int VALUE_BITS    = 16;
  localparam int NODE_BITS     = $clog2(NODE_DEPTH);
  localparam int EDGE_BITS     = $clog2(EDGE_DEPTH);
  localparam int EDGE_CNT_BITS = EDGE_BITS + 1;
  localparam int TGT_BITS      = 16;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_EXACT  = 2'd1;
  localparam logic [1:0] OP_PREFIX = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_MISSING   = 2'd1;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  localparam logic [7:0] END_BYTE = 8'd0;

  // One edge of the trie: source node, byte, and target node or stored value
  typedef struct packed {
    logic [NODE_BITS-1:0] src;
    logic [7:0]           sym;
    logic [TGT_BITS-1:0]  tgt;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

`default_nettype wire

/* hdl/tsd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one string byte per beat
interface tsd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  character;
  logic [15:0] entry_value;

  modport source (output valid, output operation, output character, output entry_value,
                  input ready);
  modport sink   (input valid, input operation, input character, input entry_value,
                  output ready);
endinterface

// Result channel: one beat per terminated string
interface tsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

`default_nettype wire

/* hdl/tsd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/trie_string_dictionary_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial trie dictionary.
// in_bus carries one string byte per beat with its operation (insert, exact
// lookup, prefix lookup) and the value to store; byte 0 ends a string.
// out_bus carries one beat per terminated string: status and found value.
// Every edge sits in one edge memory, and each accepted byte scans the
// edges written so far, one entry per cycle through the memory read port;
// no new byte is taken until the current one has finished its scan and
// decision. A byte that follows an already decided outcome is taken and
// dropped without a scan.
// The result of a terminator is registered and shows on out_bus the cycle
// after its decision. While it waits, the next string's bytes are taken; a
// further terminator holds in its decision step until the result is taken.
// Synchronous reset empties the table (edge and node counts to zero), puts
// the walk back to the root and drops any pending result; the memory itself
// needs no clearing, since only entries below the edge count are compared.

module trie_string_dictionary_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tsd_in_if.sink     in_bus,
  tsd_out_if.source  out_bus
);

  tsd_pkg::state_t state_r, state_nxt;

  // Latched input beat
  logic [1:0]                         op_r, op_nxt;
  logic [7:0]                         ch_r, ch_nxt;
  logic [15:0]                        val_r, val_nxt;

  // Scan control and hits
  logic [tsd_pkg::EDGE_CNT_BITS-1:0]  issue_r, issue_nxt;
  logic                               pend_r, pend_nxt;
  logic                               hit_end_r, hit_end_nxt;
  logic                               hit_ch_r, hit_ch_nxt;
  logic [tsd_pkg::TGT_BITS-1:0]       end_val_r, end_val_nxt;
  logic [tsd_pkg::TGT_BITS-1:0]       ch_tgt_r, ch_tgt_nxt;

  // Table and walk state
  logic [tsd_pkg::EDGE_CNT_BITS-1:0]  edge_count_r, edge_count_nxt;
  logic [tsd_pkg::NODE_BITS-1:0]      node_count_r, node_count_nxt;
  logic [tsd_pkg::NODE_BITS-1:0]      walk_r, walk_nxt;
  logic                               decided_r, decided_nxt;
  logic [1:0]                         dec_status_r, dec_status_nxt;
  logic [15:0]                        dec_value_r, dec_value_nxt;

  // Output register
  logic                               out_valid_r, out_valid_nxt;
  logic [1:0]                         out_status_r, out_status_nxt;
  logic [15:0]                        out_value_r, out_value_nxt;

  // Edge memory port
  logic                               ram_we;
  logic [tsd_pkg::EDGE_BITS-1:0]      ram_waddr;
  logic [tsd_pkg::EDGE_W-1:0]         ram_wdata;
  logic [tsd_pkg::EDGE_BITS-1:0]      ram_raddr;
  logic [tsd_pkg::EDGE_W-1:0]         ram_rdata;

  tsd_pkg::edge_t                     rd_edge;
  tsd_pkg::edge_t                     wr_edge;
  logic [tsd_pkg::NODE_BITS-1:0]      node_inc;
  logic                               table_full;
  logic                               edge_full;
  logic [1:0]                         fin_status;
  logic [15:0]                        fin_value;

  tsd_ram #(
    .WIDTH (tsd_pkg::EDGE_W),
    .DEPTH (tsd_pkg::EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_edge    = tsd_pkg::edge_t'(ram_rdata);
  assign ram_wdata  = wr_edge;
  assign ram_waddr  = edge_count_r[tsd_pkg::EDGE_BITS-1:0];
  assign ram_raddr  = issue_r[tsd_pkg::EDGE_BITS-1:0];
  assign node_inc   = node_count_r + 1'b1;
  assign edge_full  = (edge_count_r >= tsd_pkg::EDGE_CNT_BITS'(tsd_pkg::EDGE_DEPTH));
  assign table_full = (node_count_r == tsd_pkg::NODE_BITS'(tsd_pkg::NODE_DEPTH - 1))
                      || edge_full;

  assign in_bus.ready        = (state_r == tsd_pkg::ST_IDLE);
  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = out_status_r;
  assign out_bus.found_value = out_value_r;

  // Next state, scan, decision and memory write
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    ch_nxt         = ch_r;
    val_nxt        = val_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    hit_end_nxt    = hit_end_r;
    hit_ch_nxt     = hit_ch_r;
    end_val_nxt    = end_val_r;
    ch_tgt_nxt     = ch_tgt_r;
    edge_count_nxt = edge_count_r;
    node_count_nxt = node_count_r;
    walk_nxt       = walk_r;
    decided_nxt    = decided_r;
    dec_status_nxt = dec_status_r;
    dec_value_nxt  = dec_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    ram_we         = 1'b0;
    wr_edge        = '{src: walk_r, sym: ch_r, tgt: tsd_pkg::TGT_BITS'(node_inc)};
    fin_status     = dec_status_r;
    fin_value      = dec_value_r;

    // Drop the result once taken
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      tsd_pkg::ST_IDLE: begin
        if (in_bus.valid) begin
          op_nxt      = in_bus.operation;
          ch_nxt      = in_bus.character;
          val_nxt     = in_bus.entry_value;
          issue_nxt   = '0;
          pend_nxt    = 1'b0;
          hit_end_nxt = 1'b0;
          hit_ch_nxt  = 1'b0;
          // Ignore bytes once the outcome is settled
          if (!(in_bus.character != tsd_pkg::END_BYTE && decided_r)) begin
            state_nxt = tsd_pkg::ST_SCAN;
          end
        end
      end

      tsd_pkg::ST_SCAN: begin
        // Compare the entry read last cycle
        if (pend_r && rd_edge.src == walk_r) begin
          if (rd_edge.sym == tsd_pkg::END_BYTE) begin
            hit_end_nxt = 1'b1;
            end_val_nxt = rd_edge.tgt;
          end
          if (rd_edge.sym == ch_r) begin
            hit_ch_nxt = 1'b1;
            ch_tgt_nxt = rd_edge.tgt;
          end
        end
        // Advance the read address, or finish
        if (issue_r != edge_count_r) begin
          issue_nxt = issue_r + 1'b1;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = tsd_pkg::ST_DECIDE;
        end
      end

      tsd_pkg::ST_DECIDE: begin
        if (ch_r != tsd_pkg::END_BYTE) begin
          state_nxt = tsd_pkg::ST_IDLE;
          priority if (op_r == tsd_pkg::OP_PREFIX && hit_end_r) begin
            decided_nxt    = 1'b1;
            dec_status_nxt = tsd_pkg::STATUS_OK;
            dec_value_nxt  = end_val_r;
          end else if (hit_ch_r) begin
            walk_nxt = ch_tgt_r[tsd_pkg::NODE_BITS-1:0];
          end else if (op_r == tsd_pkg::OP_INSERT) begin
            if (table_full) begin
              decided_nxt    = 1'b1;
              dec_status_nxt = tsd_pkg::STATUS_FULL;
              dec_value_nxt  = '0;
            end else begin
              ram_we         = 1'b1;
              node_count_nxt = node_inc;
              edge_count_nxt = edge_count_r + 1'b1;
              walk_nxt       = node_inc;
            end
          end else begin
            decided_nxt    = 1'b1;
            dec_status_nxt = tsd_pkg::STATUS_MISSING;
            dec_value_nxt  = '0;
          end
        end else if (!out_valid_r || out_bus.ready) begin
          // Settle the outcome at the terminator
          if (!decided_r) begin
            if (op_r == tsd_pkg::OP_INSERT) begin
              fin_value = '0;
              priority if (hit_end_r) begin
                fin_status = tsd_pkg::STATUS_DUPLICATE;
              end else if (edge_full) begin
                fin_status = tsd_pkg::STATUS_FULL;
              end else begin
                fin_status     = tsd_pkg::STATUS_OK;
                ram_we         = 1'b1;
                wr_edge        = '{src: walk_r, sym: tsd_pkg::END_BYTE,
                                   tgt: tsd_pkg::TGT_BITS'(val_r[tsd_pkg::VALUE_BITS-1:0])};
                edge_count_nxt = edge_count_r + 1'b1;
              end
            end else if (hit_end_r) begin
              fin_status = tsd_pkg::STATUS_OK;
              fin_value  = end_val_r;
            end else begin
              fin_status = tsd_pkg::STATUS_MISSING;
              fin_value  = '0;
            end
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          out_value_nxt  = fin_value;
          // Back to the root with a clear outcome
          walk_nxt       = '0;
          decided_nxt    = 1'b0;
          dec_status_nxt = '0;
          dec_value_nxt  = '0;
          state_nxt      = tsd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tsd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsd_pkg::ST_IDLE;
      issue_r      <= '0;
      pend_r       <= 1'b0;
      edge_count_r <= '0;
      node_count_r <= '0;
      walk_r       <= '0;
      decided_r    <= 1'b0;
      dec_status_r <= '0;
      dec_value_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      pend_r       <= pend_nxt;
      edge_count_r <= edge_count_nxt;
      node_count_r <= node_count_nxt;
      walk_r       <= walk_nxt;
      decided_r    <= decided_nxt;
      dec_status_r <= dec_status_nxt;
      dec_value_r  <= dec_value_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ch_r         <= ch_nxt;
    val_r        <= val_nxt;
    hit_end_r    <= hit_end_nxt;
    hit_ch_r     <= hit_ch_nxt;
    end_val_r    <= end_val_nxt;
    ch_tgt_r     <= ch_tgt_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

`ifndef SYNTHESIS
  // Every node but the root is reached by its own edge
  a_edges_cover_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    edge_count_r >= tsd_pkg::EDGE_CNT_BITS'(node_count_r))
    else $error("edge count below node count");

  // The walk never points past the last allocated node
  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r <= node_count_r)
    else $error("walk node beyond node count");

  // The scan address never passes the edge count
  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r <= edge_count_r)
    else $error("scan address beyond edge count");

  // The memory is written only in the decision step, never during a scan
  a_write_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == tsd_pkg::ST_DECIDE)
    else $error("edge write outside decision step");

  // A new result comes only from a terminator's decision step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == tsd_pkg::ST_DECIDE
                           && $past(ch_r) == tsd_pkg::END_BYTE)
    else $error("result without terminator");
`endif

endmodule

`default_nettype wire
